[rtl/core/composite_key_sorter_macros.svh]
// Assertion macros shared by the sorter's checker.
// Include guarded; holds no logic.
`ifndef COMPOSITE_KEY_SORTER_MACROS_SVH
`define COMPOSITE_KEY_SORTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cks_pkg.sv]
// Shared types and field widths of the composite key sorter.
// No dependencies; imported by the top level and its checker.
package cks_pkg;

    localparam int RANK_W = 4;
    localparam int SUIT_W = 2;
    localparam int KEY_W  = RANK_W + SUIT_W;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_TAKE,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

endpackage

[rtl/core/composite_key_sorter.sv]
// Composite key sorter: one item per cycle is loaded; on the last item of a set
// the stored n items are exchange sorted by one comparator and emitted in order.
// Each compare is a memory read (S_READ) followed by a compare/write (S_CMP).
// Throughput: one item per cycle while loading; the block is not ready while sorting.
// Reset (synchronous, active low) empties the set and clears overflow; store is not cleared.
module composite_key_sorter #(
    parameter int MAX_ITEMS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cks_pkg::RANK_W-1:0] i_card_rank,
    input  logic [cks_pkg::SUIT_W-1:0] i_card_suit,
    input  logic                       i_set_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [cks_pkg::RANK_W-1:0] o_sorted_rank,
    output logic [cks_pkg::SUIT_W-1:0] o_sorted_suit,
    output logic                       o_run_last,
    output logic                       o_overflow
);
    import cks_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_key           r_mem [MAX_ITEMS];
    t_key           r_rd_data;
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_a, n_a;
    logic [CW-1:0]  r_b, n_b;
    t_key           r_min, n_min;
    logic           r_ovf, n_ovf;

    logic           w_we;
    logic [AW-1:0]  w_wa;
    t_key           w_wd;
    logic [AW-1:0]  w_rd_addr;
    logic [CW-1:0]  w_a_inc;
    logic [CW-1:0]  w_b_inc;
    logic           w_set_end;

    assign w_a_inc   = r_a + CW'(1);
    assign w_b_inc   = r_b + CW'(1);
    assign w_set_end = (w_a_inc == r_count);
    assign w_rd_addr = (r_state == S_READ) ? r_b[AW-1:0] : r_a[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_min <= n_min;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_a         = r_a;
        n_b         = r_b;
        n_min       = r_min;
        w_we        = 1'b0;
        w_wa        = r_b[AW-1:0];
        w_wd        = r_min;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        w_we    = 1'b1;
                        w_wa    = r_count[AW-1:0];
                        w_wd    = {i_card_rank, i_card_suit};
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_set_last) begin
                        n_a     = '0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_b     = w_a_inc;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                // hold the running minimum for position a
                n_min   = r_rd_data;
                n_state = (r_b < r_count) ? S_READ : S_EMIT;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // swap: the larger key goes back to slot b
                if (r_rd_data < r_min) begin
                    w_we  = 1'b1;
                    w_wa  = r_b[AW-1:0];
                    w_wd  = r_min;
                    n_min = r_rd_data;
                end
                n_b     = w_b_inc;
                n_state = (w_b_inc < r_count) ? S_READ : S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (w_set_end) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_a     = w_a_inc;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_sorted_rank = r_min[KEY_W-1:SUIT_W];
    assign o_sorted_suit = r_min[SUIT_W-1:0];
    assign o_run_last    = w_set_end;
    assign o_overflow    = r_ovf;

endmodule

[rtl/core/cks_checker.sv]
// Port-level checker for the composite key sorter, bound to the top level.
// Depends on cks_pkg and composite_key_sorter_macros.svh.
`include "composite_key_sorter_macros.svh"

module cks_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_set_last,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [cks_pkg::RANK_W-1:0] o_sorted_rank,
    input logic [cks_pkg::SUIT_W-1:0] o_sorted_suit,
    input logic                       o_run_last,
    input logic                       o_overflow
);
    import cks_pkg::*;

    `CKS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sorted_rank) && $stable(o_sorted_suit) && $stable(o_run_last) && $stable(o_overflow), "stalled result changed")
    `CKS_ASSERT_NOW(a_no_load_while_emit, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while a result is pending")
    `CKS_ASSERT_NEXT(a_set_end_reload, i_clk, i_rst_n, o_out_valid && i_out_ready && o_run_last, !o_out_valid && o_in_ready, "block not back to loading after set end")
    `CKS_ASSERT_NEXT(a_no_result_mid_set, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_set_last, !o_out_valid && o_in_ready, "result without a last item")

endmodule

bind composite_key_sorter cks_checker u_cks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_set_last    (i_set_last),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_sorted_rank (o_sorted_rank),
    .o_sorted_suit (o_sorted_suit),
    .o_run_last    (o_run_last),
    .o_overflow    (o_overflow)
);
